// File: hw/rtl/calendar_date_add_days_assert.svh
// Assertion macros shared by the calendar date checker.
`ifndef CALENDAR_DATE_ADD_DAYS_ASSERT_SVH
`define CALENDAR_DATE_ADD_DAYS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("calendar date assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("calendar date assertion failed");

`endif

// File: hw/rtl/cda_pkg.sv
// Shared types, constants and the month length function of the calendar date adder.
`timescale 1ns / 1ps

package cda_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int DEFAULT_INTERVAL_BITS = 12;

	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_MIN   = 5'd1;
	localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS = 5'd29;

	localparam logic [6:0]  CENT_LAST  = 7'd99;
	localparam logic [13:0] CENT_SIZE  = 14'd100;
	localparam logic [26:0] RECIP_100  = 27'd5243;
	localparam int          RECIP_SHIFT = 19;

	localparam logic [DAY_W-1:0] MONTH_LEN [0:15] = '{
		5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
	};

	typedef struct packed {
		logic load;
		logic div;
		logic rem;
		logic step;
		logic finish;
	} cda_cmd_t;

	typedef struct packed {
		logic day_gt_len;
	} cda_status_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		len = MONTH_LEN[m];
		if (m == MONTH_FEB && leap) begin
			len = LEAP_FEB_DAYS;
		end
		return len;
	endfunction

endpackage

// File: hw/rtl/cda_datapath.sv
// Datapath of the calendar date adder: date registers, leap year tracking and month stepping.
`timescale 1ns / 1ps

module cda_datapath #(
	parameter int INTERVAL_BITS = cda_pkg::DEFAULT_INTERVAL_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cda_pkg::cda_cmd_t              cmd,
	output cda_pkg::cda_status_t           status,
	input  logic [cda_pkg::DAY_W-1:0]      start_day,
	input  logic [cda_pkg::MONTH_W-1:0]    start_month,
	input  logic [cda_pkg::YEAR_W-1:0]     start_year,
	input  logic [INTERVAL_BITS-1:0]       add_days,
	output logic [cda_pkg::DAY_W-1:0]      due_day,
	output logic [cda_pkg::MONTH_W-1:0]    due_month,
	output logic [cda_pkg::YEAR_W-1:0]     due_year,
	output logic                           year_overflow
);
	import cda_pkg::*;

	localparam int ACC_W = INTERVAL_BITS + 1;

	logic [ACC_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;
	logic               ovf_q;
	logic [6:0]         quot_q;
	logic [6:0]         cent_rem_q;
	logic [1:0]         cent_q;
	logic [26:0]        recip_prod;
	logic [13:0]        rem_full;
	logic               leap;
	logic [DAY_W-1:0]   len;

	assign recip_prod = {13'd0, year_q} * RECIP_100;
	assign rem_full   = year_q - (14'(quot_q) * CENT_SIZE);

	// The year is leap when divisible by four but not a century, or a century divisible by four.
	assign leap = ((year_q[1:0] == 2'd0) && (cent_rem_q != 7'd0)) ||
		((cent_rem_q == 7'd0) && (cent_q == 2'd0));
	assign len = month_days(month_q, leap);
	assign status.day_gt_len = day_q > ACC_W'(len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q         <= '0;
			month_q       <= MONTH_JAN;
			year_q        <= '0;
			ovf_q         <= 1'b0;
			quot_q        <= '0;
			cent_rem_q    <= '0;
			cent_q        <= '0;
			due_day       <= DAY_MIN;
			due_month     <= MONTH_JAN;
			due_year      <= '0;
			year_overflow <= 1'b0;
		end else begin
			if (cmd.load) begin
				day_q <= ACC_W'(start_day) + ACC_W'(add_days);
				if (start_month == 4'd0) begin
					month_q <= MONTH_JAN;
				end else if (start_month > MONTH_DEC) begin
					month_q <= MONTH_DEC;
				end else begin
					month_q <= start_month;
				end
				if (start_year > YEAR_MAX) begin
					year_q <= YEAR_MAX;
					ovf_q  <= 1'b1;
				end else begin
					year_q <= start_year;
					ovf_q  <= 1'b0;
				end
			end else if (cmd.step) begin
				day_q <= day_q - ACC_W'(len);
				if (month_q == MONTH_DEC) begin
					month_q <= MONTH_JAN;
					if (year_q >= YEAR_MAX) begin
						ovf_q <= 1'b1;
					end else begin
						year_q <= year_q + 14'd1;
						if (cent_rem_q == CENT_LAST) begin
							cent_rem_q <= 7'd0;
							cent_q     <= cent_q + 2'd1;
						end else begin
							cent_rem_q <= cent_rem_q + 7'd1;
						end
					end
				end else begin
					month_q <= month_q + 4'd1;
				end
			end
			if (cmd.div) begin
				quot_q <= recip_prod[RECIP_SHIFT+6:RECIP_SHIFT];
			end
			if (cmd.rem) begin
				cent_rem_q <= rem_full[6:0];
				cent_q     <= quot_q[1:0];
			end
			if (cmd.finish) begin
				due_day       <= (day_q == ACC_W'(0)) ? DAY_MIN : day_q[DAY_W-1:0];
				due_month     <= month_q;
				due_year      <= year_q;
				year_overflow <= ovf_q;
			end
		end
	end

endmodule

// File: hw/rtl/cda_controller.sv
// Controller of the calendar date adder: sequences load, century split and month steps.
`timescale 1ns / 1ps

module cda_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	output cda_pkg::cda_cmd_t     cmd,
	input  cda_pkg::cda_status_t  status
);
	import cda_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_REM  = 2'd2;
	localparam logic [1:0] ST_STEP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	assign busy = state_q != ST_IDLE;
	assign done = done_q;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_REM;
			end
			ST_REM: begin
				cmd.rem = 1'b1;
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (status.day_gt_len) begin
					cmd.step = 1'b1;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

endmodule

// File: hw/rtl/calendar_date_add_days.sv
// Top level of the calendar date adder.
`timescale 1ns / 1ps

// Adds a day interval to a Gregorian date. An item is taken when start is high and busy is
// low; busy then stays high until the result is ready. The result is registered on the due
// ports, marked by done for a single cycle, and must be captured then, as it cannot be held
// off. After the load, the year is split into centuries, then the month loop subtracts one
// month length per cycle until the day fits the month, once per month end crossed. A new
// item may be started in the cycle that done is shown.
module calendar_date_add_days #(
	parameter int INTERVAL_BITS = cda_pkg::DEFAULT_INTERVAL_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	output logic                           done,
	input  logic [cda_pkg::DAY_W-1:0]      start_day,
	input  logic [cda_pkg::MONTH_W-1:0]    start_month,
	input  logic [cda_pkg::YEAR_W-1:0]     start_year,
	input  logic [INTERVAL_BITS-1:0]       add_days,
	output logic [cda_pkg::DAY_W-1:0]      due_day,
	output logic [cda_pkg::MONTH_W-1:0]    due_month,
	output logic [cda_pkg::YEAR_W-1:0]     due_year,
	output logic                           year_overflow
);
	import cda_pkg::*;

	cda_cmd_t    cmd;
	cda_status_t status;

	cda_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	cda_datapath #(
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.start_day     (start_day),
		.start_month   (start_month),
		.start_year    (start_year),
		.add_days      (add_days),
		.due_day       (due_day),
		.due_month     (due_month),
		.due_year      (due_year),
		.year_overflow (year_overflow)
	);

endmodule

// File: hw/rtl/cda_checker.sv
// Port checker of the calendar date adder and its binding to the top level.
`timescale 1ns / 1ps
`include "calendar_date_add_days_assert.svh"

module cda_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [cda_pkg::DAY_W-1:0]      due_day,
	input logic [cda_pkg::MONTH_W-1:0]    due_month,
	input logic [cda_pkg::YEAR_W-1:0]     due_year
);
	import cda_pkg::*;

	`CDA_ASSERT_NEXT(a_take_sets_busy, clk, arst_n, start && !busy, busy)
	`CDA_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`CDA_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	`CDA_ASSERT_SAME(a_date_valid, clk, arst_n, done,
		due_day != 5'd0 && due_month >= MONTH_JAN && due_month <= MONTH_DEC)
	`CDA_ASSERT_SAME(a_year_sat, clk, arst_n, done, due_year <= YEAR_MAX)

endmodule

bind calendar_date_add_days cda_checker u_cda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.due_day   (due_day),
	.due_month (due_month),
	.due_year  (due_year)
);
